### rtl/hllf_pkg.sv
`timescale 1ns / 1ps
// Shared constants and types for the HLL face flux pipeline.
// No dependencies; every other file of the block depends on this one.
package hllf_pkg;

  localparam int DATA_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int CFG_W          = 17;
  localparam logic [CFG_W-1:0] MIN_DEN_RESET = CFG_W'(1);

  typedef enum logic [1:0] {
    REGION_LEFT  = 2'd0,
    REGION_RIGHT = 2'd1,
    REGION_STAR  = 2'd2
  } region_t;

  // Per-word control that travels with the data down the pipe
  typedef struct packed {
    logic    star;    // result comes from the divider
    region_t region;
  } ctl_t;

endpackage

### rtl/hllf_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces: face word in, flux word out.
// Depends on hllf_pkg for default widths.
interface hllf_req_if #(parameter int DATA_WIDTH = hllf_pkg::DATA_WIDTH_DEF) ();
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] speed_left;
  logic signed [DATA_WIDTH-1:0] speed_right;
  logic signed [DATA_WIDTH-1:0] flux_left;
  logic signed [DATA_WIDTH-1:0] flux_right;
  logic signed [DATA_WIDTH-1:0] value_left;
  logic signed [DATA_WIDTH-1:0] value_right;
  modport source(output valid, speed_left, speed_right, flux_left, flux_right,
                 value_left, value_right, input ready);
  modport sink(input valid, speed_left, speed_right, flux_left, flux_right,
               value_left, value_right, output ready);
endinterface

interface hllf_rsp_if #(parameter int DATA_WIDTH = hllf_pkg::DATA_WIDTH_DEF) ();
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] face_flux;
  logic [1:0]                   region;
  logic                         saturated;
  modport source(output valid, face_flux, region, saturated, input ready);
  modport sink(input valid, face_flux, region, saturated, output ready);
endinterface

### rtl/hllf_front.sv
`timescale 1ns / 1ps
// Front of the flux pipe: region select, products, numerator and divider setup.
// Six register stages. Depends on hllf_pkg.
module hllf_front #(
  parameter int DATA_WIDTH = hllf_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = hllf_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                en,
  input  logic                                in_valid,
  input  logic signed [DATA_WIDTH-1:0]        sl,
  input  logic signed [DATA_WIDTH-1:0]        sr,
  input  logic signed [DATA_WIDTH-1:0]        fl,
  input  logic signed [DATA_WIDTH-1:0]        fr,
  input  logic signed [DATA_WIDTH-1:0]        ql,
  input  logic signed [DATA_WIDTH-1:0]        qr,
  input  logic [hllf_pkg::CFG_W-1:0]          min_den,
  output logic                                out_valid,
  output hllf_pkg::ctl_t                      out_ctl,
  output logic [DATA_WIDTH-1:0]               out_bypass,
  output logic                                out_neg,
  output logic                                out_ovf,
  output logic [DATA_WIDTH+FRAC_BITS-1:0]     out_r,
  output logic [DATA_WIDTH-1:0]               out_nlow,
  output logic [DATA_WIDTH+FRAC_BITS-1:0]     out_d
);
  import hllf_pkg::*;

  localparam int W     = DATA_WIDTH;
  localparam int F     = FRAC_BITS;
  localparam int DVW   = W + F;
  localparam int NUMW  = 3 * W + F + 2;
  localparam int NST   = 6;

  logic           v     [NST];
  ctl_t           ctl   [NST];
  logic [W-1:0]   byp   [NST];
  logic [W-1:0]   den   [NST-1];

  // stage 1
  logic signed [2*W-1:0] a1, b1;
  logic signed [W:0]     qd1;
  logic signed [W-1:0]   sl1, sr1;
  // stage 2
  logic signed [2*W:0]   ab2, c2;
  logic signed [W-1:0]   sr2;
  // stage 3
  logic signed [2*W:0]   ab3, plo3, phi3;
  // stage 4..6
  logic signed [NUMW-1:0] num4;
  logic [NUMW-1:0]        abs5;
  logic                   neg5;

  // region decision
  logic signed [W:0] den_w;
  logic [W:0]        min_ext;
  ctl_t              ctl_in;
  logic [W-1:0]      byp_in;

  always_comb begin
    den_w   = {sr[W-1], sr} - {sl[W-1], sl};
    min_ext = (W+1)'(min_den);
    ctl_in  = '{star: 1'b0, region: REGION_LEFT};
    byp_in  = fl;
    if (sl[W-1]) begin
      if (sr[W-1] || sr == '0) begin
        ctl_in.region = REGION_RIGHT;
        byp_in        = fr;
      end else begin
        ctl_in.region = REGION_STAR;
        ctl_in.star   = $unsigned(den_w) > min_ext;
        byp_in        = '0;
      end
    end
  end

  // advance valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NST; i++) v[i] <= 1'b0;
    end else if (en) begin
      v[0] <= in_valid;
      for (int i = 1; i < NST; i++) v[i] <= v[i-1];
    end
  end

  // advance control and bypass words
  always_ff @(posedge clk) begin
    if (en) begin
      ctl[0] <= ctl_in;
      byp[0] <= byp_in;
      den[0] <= den_w[W-1:0];
      for (int i = 1; i < NST; i++) begin
        ctl[i] <= ctl[i-1];
        byp[i] <= byp[i-1];
      end
      for (int i = 1; i < NST-1; i++) den[i] <= den[i-1];
    end
  end

  // arithmetic stages
  always_ff @(posedge clk) begin
    if (en) begin
      a1   <= sr * fl;
      b1   <= sl * fr;
      qd1  <= {qr[W-1], qr} - {ql[W-1], ql};
      sl1  <= sl;
      sr1  <= sr;

      ab2  <= {a1[2*W-1], a1} - {b1[2*W-1], b1};
      c2   <= sl1 * qd1;
      sr2  <= sr1;

      ab3  <= ab2;
      plo3 <= sr2 * $signed({1'b0, c2[W-1:0]});
      phi3 <= sr2 * $signed(c2[2*W:W]);

      num4 <= (NUMW'(ab3) <<< F) + (NUMW'(phi3) <<< W) + NUMW'(plo3);

      neg5 <= num4[NUMW-1];
      abs5 <= num4[NUMW-1] ? NUMW'(-num4) : NUMW'(num4);

      out_neg  <= neg5;
      out_ovf  <= abs5 >= NUMW'({den[NST-2], {(F+W){1'b0}}});
      out_r    <= abs5[W +: DVW];
      out_nlow <= abs5[W-1:0];
      out_d    <= {den[NST-2], {F{1'b0}}};
    end
  end

  assign out_valid  = v[NST-1];
  assign out_ctl    = ctl[NST-1];
  assign out_bypass = byp[NST-1];

endmodule

### rtl/hllf_div_step.sv
`timescale 1ns / 1ps
// One restoring-division step of the quotient pipe: one quotient bit a stage.
// Depends on hllf_pkg.
module hllf_div_step #(
  parameter int DATA_WIDTH = hllf_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = hllf_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                en,
  input  logic                                i_valid,
  input  hllf_pkg::ctl_t                      i_ctl,
  input  logic [DATA_WIDTH-1:0]               i_bypass,
  input  logic                                i_neg,
  input  logic                                i_ovf,
  input  logic [DATA_WIDTH+FRAC_BITS-1:0]     i_r,
  input  logic [DATA_WIDTH-1:0]               i_nlow,
  input  logic [DATA_WIDTH+FRAC_BITS-1:0]     i_d,
  input  logic [DATA_WIDTH-1:0]               i_q,
  output logic                                o_valid,
  output hllf_pkg::ctl_t                      o_ctl,
  output logic [DATA_WIDTH-1:0]               o_bypass,
  output logic                                o_neg,
  output logic                                o_ovf,
  output logic [DATA_WIDTH+FRAC_BITS-1:0]     o_r,
  output logic [DATA_WIDTH-1:0]               o_nlow,
  output logic [DATA_WIDTH+FRAC_BITS-1:0]     o_d,
  output logic [DATA_WIDTH-1:0]               o_q
);
  import hllf_pkg::*;

  localparam int W   = DATA_WIDTH;
  localparam int DVW = DATA_WIDTH + FRAC_BITS;

  logic [DVW:0] trial, diff;
  logic         ge;

  // shift in the next dividend bit and try a subtract
  always_comb begin
    trial = {i_r, i_nlow[W-1]};
    diff  = trial - {1'b0, i_d};
    ge    = trial >= {1'b0, i_d};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (en) begin
      o_valid <= i_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      o_ctl    <= i_ctl;
      o_bypass <= i_bypass;
      o_neg    <= i_neg;
      o_ovf    <= i_ovf;
      o_r      <= ge ? diff[DVW-1:0] : trial[DVW-1:0];
      o_nlow   <= {i_nlow[W-2:0], 1'b0};
      o_d      <= i_d;
      o_q      <= {i_q[W-2:0], ge};
    end
  end

endmodule

### rtl/hll_riemann_flux_top.sv
`timescale 1ns / 1ps
// Top level of the HLL face flux pipeline: front, quotient pipe, round/clip.
// Depends on hllf_pkg, hllf_if, hllf_front and hllf_div_step.
//
//   channel  dir  words                                          handshake
//   req      in   speeds, fluxes, values of one face (left/right) valid/ready
//   rsp      out  face_flux, region, saturated                   valid/ready
//   cfg      in   min_denominator                                cfg_we
//
// One face word enters per cycle while rsp is not stalled; the path runs through
// the six-stage front, one divider stage per quotient bit, the rounding stage
// and the output register.
// rst is synchronous and clears valid bits and min_denominator (to 1).
// A stalled rsp freezes the whole pipe; req.ready drops only while the output
// word waits and rsp.ready is low.
module hll_riemann_flux_top #(
  parameter int DATA_WIDTH = hllf_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = hllf_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [hllf_pkg::CFG_W-1:0]  cfg_data,
  hllf_req_if.sink                    req,
  hllf_rsp_if.source                  rsp
);
  import hllf_pkg::*;

  localparam int W   = DATA_WIDTH;
  localparam int DVW = DATA_WIDTH + FRAC_BITS;
  localparam logic [W:0] LIM_POS = {2'b00, {(W-1){1'b1}}};
  localparam logic [W:0] LIM_NEG = {2'b01, {(W-1){1'b0}}};

  logic [CFG_W-1:0] min_den;
  logic             en;

  logic           c_valid  [W+1];
  ctl_t           c_ctl    [W+1];
  logic [W-1:0]   c_bypass [W+1];
  logic           c_neg    [W+1];
  logic           c_ovf    [W+1];
  logic [DVW-1:0] c_r      [W+1];
  logic [W-1:0]   c_nlow   [W+1];
  logic [DVW-1:0] c_d      [W+1];
  logic [W-1:0]   c_q      [W+1];

  logic           rd_valid;
  ctl_t           rd_ctl;
  logic [W-1:0]   rd_bypass;
  logic           rd_neg;
  logic           rd_ovf;
  logic [W:0]     rd_q;

  logic           sat_next;
  logic [W-1:0]   flux_next;

  // whole pipe moves unless the output word is held
  assign en        = !rsp.valid || rsp.ready;
  assign req.ready = en;

  // hold the guard register
  always_ff @(posedge clk) begin
    if (rst) begin
      min_den <= MIN_DEN_RESET;
    end else if (cfg_we) begin
      min_den <= cfg_data;
    end
  end

  hllf_front #(.DATA_WIDTH(W), .FRAC_BITS(FRAC_BITS)) u_front (
    .clk, .rst, .en,
    .in_valid   (req.valid & req.ready),
    .sl         (req.speed_left),
    .sr         (req.speed_right),
    .fl         (req.flux_left),
    .fr         (req.flux_right),
    .ql         (req.value_left),
    .qr         (req.value_right),
    .min_den    (min_den),
    .out_valid  (c_valid[0]),
    .out_ctl    (c_ctl[0]),
    .out_bypass (c_bypass[0]),
    .out_neg    (c_neg[0]),
    .out_ovf    (c_ovf[0]),
    .out_r      (c_r[0]),
    .out_nlow   (c_nlow[0]),
    .out_d      (c_d[0])
  );
  assign c_q[0] = '0;

  for (genvar g = 0; g < W; g++) begin : g_div
    hllf_div_step #(.DATA_WIDTH(W), .FRAC_BITS(FRAC_BITS)) u_step (
      .clk, .rst, .en,
      .i_valid (c_valid[g]),   .i_ctl  (c_ctl[g]),  .i_bypass (c_bypass[g]),
      .i_neg   (c_neg[g]),     .i_ovf  (c_ovf[g]),  .i_r      (c_r[g]),
      .i_nlow  (c_nlow[g]),    .i_d    (c_d[g]),    .i_q      (c_q[g]),
      .o_valid (c_valid[g+1]), .o_ctl  (c_ctl[g+1]), .o_bypass (c_bypass[g+1]),
      .o_neg   (c_neg[g+1]),   .o_ovf  (c_ovf[g+1]), .o_r      (c_r[g+1]),
      .o_nlow  (c_nlow[g+1]),  .o_d    (c_d[g+1]),   .o_q      (c_q[g+1])
    );
  end

  // round to nearest, ties away from zero
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else if (en) begin
      rd_valid <= c_valid[W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rd_ctl    <= c_ctl[W];
      rd_bypass <= c_bypass[W];
      rd_neg    <= c_neg[W];
      rd_ovf    <= c_ovf[W];
      rd_q      <= {1'b0, c_q[W]} +
                   (W+1)'({c_r[W], 1'b0} >= {1'b0, c_d[W]});
    end
  end

  // clip and apply sign on divider results, else pass the bypass word
  always_comb begin
    sat_next  = 1'b0;
    flux_next = rd_bypass;
    if (rd_ctl.star) begin
      if (rd_neg) begin
        sat_next  = rd_ovf || rd_q > LIM_NEG;
        flux_next = sat_next ? LIM_NEG[W-1:0] : -rd_q[W-1:0];
      end else begin
        sat_next  = rd_ovf || rd_q > LIM_POS;
        flux_next = sat_next ? LIM_POS[W-1:0] : rd_q[W-1:0];
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (en) begin
      rsp.valid <= rd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rsp.face_flux <= flux_next;
      rsp.region    <= rd_ctl.region;
      rsp.saturated <= sat_next;
    end
  end

  a_sat_star: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.saturated |-> rsp.region == REGION_STAR)
    else $error("saturation outside star region");

  a_sat_rail: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.saturated |->
      rsp.face_flux == LIM_POS[W-1:0] || rsp.face_flux == LIM_NEG[W-1:0])
    else $error("saturated word not at a rail");

  a_reset_empty: assert property (@(posedge clk) rst |=> !rsp.valid)
    else $error("output valid right after reset");

  a_stall_front: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && !rsp.ready |=> $stable(c_valid[0]))
    else $error("front moved during a stall");

endmodule
